// ===== rtl/core/htlp_pkg.sv =====
// types and codes for the linear-probing hash table
// shared by the top level and any block that drives or watches its ports
// no dependencies
package htlp_pkg;

	localparam int KEY_W   = 31;
	localparam int VALUE_W = 32;

	// operation codes
	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_LOOKUP = 2'd1;
	localparam logic [1:0] OP_REMOVE = 2'd2;

	// result status codes
	localparam logic [2:0] ST_INSERTED = 3'd0;
	localparam logic [2:0] ST_UPDATED  = 3'd1;
	localparam logic [2:0] ST_FULL     = 3'd2;
	localparam logic [2:0] ST_FOUND    = 3'd3;
	localparam logic [2:0] ST_MISSING  = 3'd4;
	localparam logic [2:0] ST_REMOVED  = 3'd5;

	// slot marks
	localparam logic [1:0] MARK_EMPTY = 2'd0;
	localparam logic [1:0] MARK_LIVE  = 2'd1;
	localparam logic [1:0] MARK_TOMB  = 2'd2;

	typedef struct packed {
		logic [1:0]                op;
		logic [KEY_W-1:0]          key;
		logic signed [VALUE_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic [2:0]                status;
		logic                      found;
		logic signed [VALUE_W-1:0] read_value;
	} rsp_t;

	typedef struct packed {
		logic [1:0]                mark;
		logic [KEY_W-1:0]          key;
		logic signed [VALUE_W-1:0] value;
	} entry_t;

endpackage

// ===== rtl/core/hash_table_linear_probe.sv =====
// open-addressing key/value table with linear probing and tombstones
// one synchronous slot memory, probe sequencer and response register
// depends on htlp_pkg
module hash_table_linear_probe import htlp_pkg::*; #(
	parameter int TABLE_SIZE = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t req,
	output logic done,
	output rsp_t rsp
);

	// Each command (insert, lookup, remove) is taken when start is high and busy is low;
	// its single response appears on rsp in the cycle busy drops, with done high for
	// exactly that cycle and no way to hold it off. The slot memory gives one probe per
	// clock: busy covers a read step and then one probe per slot probed (1 to TABLE_SIZE),
	// plus a hash step to reduce the key mod TABLE_SIZE when TABLE_SIZE is not a power of
	// two. An unused op code answers "not found" in the next cycle without raising busy.
	// After reset the block stays busy while it marks every slot empty.

	localparam int IDXW = (TABLE_SIZE > 2) ? $clog2(TABLE_SIZE) : 1;
	localparam bit IS_POW2 = (TABLE_SIZE & (TABLE_SIZE - 1)) == 0;
	localparam logic [IDXW-1:0] LAST_IDX = IDXW'(TABLE_SIZE - 1);
	localparam logic [KEY_W-1:0] SIZE_K  = KEY_W'(TABLE_SIZE);
	localparam int PROD_W    = KEY_W + 32;
	localparam int MOD_SHIFT = KEY_W + IDXW;
	localparam logic [31:0] RECIP = 32'((64'd1 << MOD_SHIFT) / TABLE_SIZE);

	typedef enum logic [4:0] {
		S_CLEAR = 5'b00001,
		S_IDLE  = 5'b00010,
		S_HASH  = 5'b00100,
		S_READ  = 5'b01000,
		S_EVAL  = 5'b10000
	} state_t;

	state_t state_q;
	req_t   req_q;
	logic [IDXW-1:0] idx_q;
	logic [IDXW-1:0] cnt_q;
	logic [IDXW-1:0] tomb_idx_q;
	logic tomb_vld_q;
	logic hash_ph_q;
	logic [PROD_W-1:0] prod_q;
	logic done_q;
	rsp_t rsp_q;

	entry_t mem [TABLE_SIZE];
	entry_t rd_q;
	logic mem_we;
	logic [IDXW-1:0] mem_wa;
	logic [IDXW-1:0] mem_ra;
	entry_t mem_wd;

	logic [IDXW-1:0] nxt_idx;
	logic [KEY_W-1:0] quot;
	logic [KEY_W-1:0] mod_rem;
	logic [IDXW-1:0] rem_d;
	logic is_empty, is_live, is_tomb, is_hit, is_last, finish;
	logic tomb_vld_eff;
	logic [IDXW-1:0] tomb_idx_eff;
	logic [IDXW-1:0] ins_idx;
	rsp_t rsp_d;

	assign nxt_idx = (idx_q == LAST_IDX) ? '0 : idx_q + 1'b1;

	// reciprocal multiply gives a quotient that is low by at most one
	assign quot    = KEY_W'(prod_q >> MOD_SHIFT);
	assign mod_rem = req_q.key - KEY_W'(quot * SIZE_K);
	assign rem_d   = (mod_rem >= SIZE_K) ? IDXW'(mod_rem - SIZE_K) : IDXW'(mod_rem);

	assign is_empty = rd_q.mark == MARK_EMPTY;
	assign is_live  = rd_q.mark == MARK_LIVE;
	assign is_tomb  = !is_empty && !is_live;
	assign is_hit   = is_live && (rd_q.key == req_q.key);
	assign is_last  = cnt_q == LAST_IDX;
	assign finish   = is_empty || is_hit || is_last;

	// a tombstone on the final probe still counts as the last one passed
	assign tomb_vld_eff = is_tomb || tomb_vld_q;
	assign tomb_idx_eff = is_tomb ? idx_q : tomb_idx_q;
	assign ins_idx      = tomb_vld_eff ? tomb_idx_eff : idx_q;

	always_comb begin
		mem_we = 1'b0;
		mem_wa = idx_q;
		mem_wd = '{mark: MARK_EMPTY, key: req_q.key, value: req_q.value};
		mem_ra = (state_q == S_EVAL) ? nxt_idx : idx_q;
		rsp_d  = '{status: ST_MISSING, found: 1'b0, read_value: '0};
		case (state_q)
			S_CLEAR: begin
				mem_we = 1'b1;
			end
			S_EVAL: begin
				if (is_hit) begin
					case (req_q.op)
						OP_INSERT: begin
							mem_we = 1'b1;
							mem_wd.mark = MARK_LIVE;
							rsp_d.status = ST_UPDATED;
						end
						OP_LOOKUP: begin
							rsp_d.status = ST_FOUND;
							rsp_d.found = 1'b1;
							rsp_d.read_value = rd_q.value;
						end
						OP_REMOVE: begin
							mem_we = 1'b1;
							mem_wd = rd_q;
							mem_wd.mark = MARK_TOMB;
							rsp_d.status = ST_REMOVED;
						end
						default: begin
							rsp_d.status = ST_MISSING;
						end
					endcase
				end else if (req_q.op == OP_INSERT) begin
					if (tomb_vld_eff || is_empty) begin
						mem_we = finish;
						mem_wa = ins_idx;
						mem_wd.mark = MARK_LIVE;
						rsp_d.status = ST_INSERTED;
					end else begin
						rsp_d.status = ST_FULL;
					end
				end
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rd_q <= mem[mem_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			idx_q <= '0;
			cnt_q <= '0;
			tomb_vld_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					idx_q <= nxt_idx;
					if (idx_q == LAST_IDX) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					cnt_q <= '0;
					tomb_vld_q <= 1'b0;
					if (start) begin
						if (req.op == OP_INSERT || req.op == OP_LOOKUP ||
						    req.op == OP_REMOVE) begin
							if (IS_POW2) begin
								idx_q <= req.key[IDXW-1:0];
								state_q <= S_READ;
							end else begin
								idx_q <= '0;
								state_q <= S_HASH;
							end
						end else begin
							done_q <= 1'b1;
						end
					end
				end
				S_HASH: begin
					if (hash_ph_q) begin
						idx_q <= rem_d;
						state_q <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_EVAL;
				end
				S_EVAL: begin
					if (finish) begin
						done_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						idx_q <= nxt_idx;
						cnt_q <= cnt_q + 1'b1;
						tomb_vld_q <= tomb_vld_eff;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload registers, no reset needed
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			req_q <= req;
			hash_ph_q <= 1'b0;
			rsp_q <= '{status: ST_MISSING, found: 1'b0, read_value: '0};
		end
		if (state_q == S_HASH) begin
			prod_q <= {32'b0, req_q.key} * {31'b0, RECIP};
			hash_ph_q <= 1'b1;
		end
		if (state_q == S_EVAL) begin
			tomb_idx_q <= tomb_idx_eff;
			if (finish) begin
				rsp_q <= rsp_d;
			end
		end
	end

	assign busy = state_q != S_IDLE;
	assign done = done_q;
	assign rsp  = rsp_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("response strobed while a command is still in progress");

	a_accept_answered: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done))
		else $error("accepted command neither in progress nor answered");

	a_found_status: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.found) |-> (rsp.status == ST_FOUND))
		else $error("found flag without found status");

	a_write_eval: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == S_CLEAR || (state_q == S_EVAL && finish)))
		else $error("slot written outside clearing or command completion");

endmodule

// ===== tb/htlp_table_check.sv =====
`timescale 1ns / 100ps
// watches the hash table's command and result channels, keeps a shadow copy of the slots,
// predicts each answer and compares it field by field with what the block returns
// depends on htlp_pkg
module htlp_table_check import htlp_pkg::*; #(
	parameter int TABLE_SIZE = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic busy,
	input  req_t req,
	input  logic done,
	input  rsp_t rsp,
	output int   fail_count,
	output int   outstanding
);

	localparam int SHOW_MAX = 100;

	logic [1:0]                shadow_mark  [TABLE_SIZE];
	logic [KEY_W-1:0]          shadow_key   [TABLE_SIZE];
	logic signed [VALUE_W-1:0] shadow_value [TABLE_SIZE];

	rsp_t answers_due [$];
	int   due_count;
	int   mismatches;
	int   result_no;

	// anything still owed at the end counts against the run
	assign outstanding = due_count;
	assign fail_count  = mismatches + due_count;

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		if (mismatches < SHOW_MAX)
			$display("%0t result %0d: %s got %0h want %0h", $time, result_no, what, got, want);
		mismatches++;
	endtask

	// walk the probe sequence on the shadow slots, apply the operation, return the answer
	function automatic rsp_t probe_and_apply(req_t r);
		rsp_t ans;
		int   idx;
		int   n;
		int   hit;
		int   stop;
		int   tomb;
		int   dst;
		ans.status     = ST_MISSING;
		ans.found      = 1'b0;
		ans.read_value = '0;
		if (r.op == OP_INSERT || r.op == OP_LOOKUP || r.op == OP_REMOVE) begin
			hit  = -1;
			stop = -1;
			tomb = -1;
			n    = 0;
			idx  = int'(r.key % TABLE_SIZE);
			while (n < TABLE_SIZE && hit < 0 && stop < 0) begin
				if (shadow_mark[idx] == MARK_EMPTY) begin
					stop = idx;
				end else if (shadow_mark[idx] == MARK_LIVE) begin
					if (shadow_key[idx] == r.key)
						hit = idx;
				end else begin
					// tombstone, and any stray mark is treated the same way
					tomb = idx;
				end
				idx = (idx + 1) % TABLE_SIZE;
				n++;
			end
			case (r.op)
				OP_INSERT: begin
					if (hit >= 0) begin
						shadow_value[hit] = r.value;
						ans.status = ST_UPDATED;
					end else begin
						dst = (tomb >= 0) ? tomb : stop;
						if (dst >= 0) begin
							shadow_mark[dst]  = MARK_LIVE;
							shadow_key[dst]   = r.key;
							shadow_value[dst] = r.value;
							ans.status = ST_INSERTED;
						end else begin
							ans.status = ST_FULL;
						end
					end
				end
				OP_LOOKUP: begin
					if (hit >= 0) begin
						ans.status     = ST_FOUND;
						ans.found      = 1'b1;
						ans.read_value = shadow_value[hit];
					end
				end
				default: begin
					if (hit >= 0) begin
						shadow_mark[hit] = MARK_TOMB;
						ans.status = ST_REMOVED;
					end
				end
			endcase
		end
		return ans;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			for (int i = 0; i < TABLE_SIZE; i++)
				shadow_mark[i] = MARK_EMPTY;
			answers_due.delete();
			due_count  = 0;
			mismatches = 0;
			result_no  = 0;
		end else begin
			if (start && !busy)
				answers_due.push_back(probe_and_apply(req));
			if (done) begin
				if (answers_due.size() == 0) begin
					report_mismatch("result with nothing owed, status", 32'(rsp.status), '0);
				end else begin
					want = answers_due.pop_front();
					if (rsp.status !== want.status)
						report_mismatch("status", 32'(rsp.status), 32'(want.status));
					if (rsp.found !== want.found)
						report_mismatch("found", 32'(rsp.found), 32'(want.found));
					if (rsp.read_value !== want.read_value)
						report_mismatch("read_value", rsp.read_value, want.read_value);
				end
				result_no++;
			end
			due_count = answers_due.size();
		end
	end

endmodule

// ===== tb/hash_table_linear_probe_tb.sv =====
`timescale 1ns / 100ps
// top of the hash table testbench: clock, reset, command stimulus and the verdict
// depends on htlp_pkg, hash_table_linear_probe and htlp_table_check
module hash_table_linear_probe_tb;
	import htlp_pkg::*;

	localparam int TABLE_SIZE   = 16;
	localparam int ITEM_TARGET  = 950;
	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 64;

	// op code the block does not define, it must answer not found
	localparam logic [1:0] OP_SPARE = 2'd3;

	localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;
	localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;
	localparam logic [KEY_W-1:0]          KEY_MAX   = {KEY_W{1'b1}};

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic done;
	req_t req;
	rsp_t rsp;
	int   fail_count;
	int   outstanding;

	int   issued;
	int   burst_left;
	int   quiet_cycles;
	logic [KEY_W-1:0] key_pool [$];

	hash_table_linear_probe #(.TABLE_SIZE(TABLE_SIZE)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.rsp    (rsp)
	);

	htlp_table_check #(.TABLE_SIZE(TABLE_SIZE)) table_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.req         (req),
		.done        (done),
		.rsp         (rsp),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic signed [VALUE_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0:       return VALUE_MIN;
			1:       return VALUE_MAX;
			2:       return '0;
			3:       return -1;
			default: return $urandom;
		endcase
	endfunction

	// one command transfer, then the sender's burst/gap pacing
	task automatic send_cmd(logic [1:0] op, logic [KEY_W-1:0] key,
			logic signed [VALUE_W-1:0] value);
		req_t junk;
		int   gap;
		@(negedge clk);
		start <= 1'b1;
		req   <= '{op: op, key: key, value: value};
		do @(posedge clk); while (busy);
		issued++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap        = $urandom_range(1, 10);
			junk.op    = 2'($urandom);
			junk.key   = KEY_W'($urandom);
			junk.value = $urandom;
			@(negedge clk);
			start <= 1'b0;
			req   <= junk;
			repeat (gap - 1) @(negedge clk);
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
				: $urandom_range(0, 12);
		end
	endtask

	// stall watchdog: no command and no result for too long
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int               roll;
		int               ins_w;
		int               rem_w;
		int               round_len;
		int               pool_size;
		int               base;
		logic [KEY_W-1:0] kk;
		arst_n       = 1'b0;
		start        = 1'b0;
		req          = '0;
		issued       = 0;
		burst_left   = 0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// directed: extremes, collisions, tombstone reuse, then a full table
		send_cmd(OP_INSERT, '0, VALUE_MIN);
		send_cmd(OP_INSERT, KEY_MAX, VALUE_MAX);
		send_cmd(OP_INSERT, 31'd16, 32'sd5);
		send_cmd(OP_INSERT, '0, -1);
		send_cmd(OP_LOOKUP, 31'd16, VALUE_MAX);
		send_cmd(OP_LOOKUP, 31'd32, '0);
		send_cmd(OP_REMOVE, '0, '0);
		send_cmd(OP_LOOKUP, 31'd16, '0);
		send_cmd(OP_INSERT, 31'd48, 32'sd7);
		send_cmd(OP_REMOVE, '0, '0);
		send_cmd(OP_SPARE, 31'd16, VALUE_MIN);
		key_pool.push_back(KEY_MAX);
		key_pool.push_back(31'd16);
		key_pool.push_back(31'd48);
		for (int k = 2; k < TABLE_SIZE - 1; k++) begin
			kk = KEY_W'(k + TABLE_SIZE * $urandom_range(1, 9999));
			send_cmd(OP_INSERT, kk, pick_value());
			key_pool.push_back(kk);
		end
		// every slot live now: insert reports full, misses wrap all the way
		send_cmd(OP_INSERT, 31'd17, 32'sd9);
		send_cmd(OP_LOOKUP, 31'd17, '0);

		// random rounds over a crowded key pool, each round drained by removes
		while (issued < ITEM_TARGET) begin
			round_len = $urandom_range(50, 140);
			ins_w     = $urandom_range(30, 65);
			rem_w     = $urandom_range(10, 25);
			repeat (round_len) begin
				roll = $urandom_range(0, 99);
				kk   = key_pool[$urandom_range(0, key_pool.size() - 1)];
				if (roll < 3) begin
					send_cmd(OP_SPARE, kk, $urandom);
				end else if (roll < 3 + ins_w) begin
					send_cmd(OP_INSERT, kk, pick_value());
				end else begin
					// stray keys only for lookups and removes, so the table never holds them
					if ($urandom_range(0, 9) == 0)
						kk = KEY_W'($urandom);
					if (roll < 3 + ins_w + rem_w)
						send_cmd(OP_REMOVE, kk, $urandom);
					else
						send_cmd(OP_LOOKUP, kk, $urandom);
				end
			end
			foreach (key_pool[i])
				send_cmd(OP_REMOVE, key_pool[i], $urandom);
			key_pool.delete();
			pool_size = $urandom_range(6, 28);
			base      = $urandom_range(0, TABLE_SIZE - 1);
			repeat (pool_size) begin
				kk = KEY_W'($urandom);
				// most keys pile onto a few neighboring home slots
				if ($urandom_range(0, 3) != 0)
					kk[3:0] = 4'(base + $urandom_range(0, 4));
				key_pool.push_back(kk);
			end
		end

		@(negedge clk);
		start <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/htlp_pkg.sv
rtl/core/hash_table_linear_probe.sv
tb/htlp_table_check.sv
tb/hash_table_linear_probe_tb.sv
